/* src/utf8d_pkg.sv */
// Shared types and constants for the lenient UTF-8 decoder.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned HELD_DEPTH  = 2;
  localparam int unsigned RIDX_W      = $clog2(MAX_RESULTS);

  // sequence lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // byte tags
  localparam logic [1:0] TAG_CONT  = 2'b10;
  localparam logic [2:0] TAG_LEAD2 = 3'b110;
  localparam logic [3:0] TAG_LEAD3 = 4'b1110;
  localparam logic [4:0] TAG_LEAD4 = 5'b11110;

  localparam logic [CP_W-1:0] CP_UPPER_A = 21'h41;
  localparam logic [CP_W-1:0] CP_UPPER_Z = 21'h5A;
  localparam logic [CP_W-1:0] CP_FOLD    = 21'h20;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            raw;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [RIDX_W-1:0]         last_idx;
    logic                      text_end;
  } pkt_t;

endpackage

`default_nettype wire

/* src/utf8d_front.sv */
// Front end: accepts bytes, tracks the open sequence and builds result packets.
`default_nettype none

module utf8d_front
  import utf8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       text_end,
  input  wire logic       q_full,
  output logic            push,
  output pkt_t            push_pkt
);

  logic [7:0]      lead_byte, lead_byte_next;
  logic [2:0]      exp_len, exp_len_next;
  logic [1:0]      held_cnt, held_cnt_next;
  logic [7:0]      held [HELD_DEPTH];
  logic [CP_W-1:0] partial, partial_next;
  logic            accept;
  logic [2:0]      n;
  logic            hold_wr;
  logic [CP_W-1:0] pv;
  result_t [MAX_RESULTS-1:0] res;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    n              = 3'd0;
    res            = '0;
    hold_wr        = 1'b0;
    lead_byte_next = lead_byte;
    exp_len_next   = exp_len;
    held_cnt_next  = held_cnt;
    partial_next   = partial;
    pv             = {partial[CP_W-7:0], data_byte[5:0]};

    if (exp_len != LEN_NONE && data_byte[7:6] == TAG_CONT) begin
      if ({1'b0, held_cnt} + 3'd2 >= exp_len) begin
        res[n[RIDX_W-1:0]] = '{cp: pv, raw: 1'b0};
        n = n + 3'd1;
        exp_len_next   = LEN_NONE;
        held_cnt_next  = 2'd0;
        partial_next   = '0;
        lead_byte_next = 8'd0;
      end else begin
        hold_wr       = 1'b1;
        held_cnt_next = held_cnt + 2'd1;
        partial_next  = pv;
      end
    end else begin
      if (exp_len != LEN_NONE) begin
        res[n[RIDX_W-1:0]] = '{cp: CP_W'(lead_byte), raw: 1'b1};
        n = n + 3'd1;
        for (int i = 0; i < HELD_DEPTH; i++) begin
          if (2'(i) < held_cnt) begin
            res[n[RIDX_W-1:0]] = '{cp: CP_W'(held[i]), raw: 1'b1};
            n = n + 3'd1;
          end
        end
        exp_len_next   = LEN_NONE;
        held_cnt_next  = 2'd0;
        partial_next   = '0;
        lead_byte_next = 8'd0;
      end
      if (!data_byte[7]) begin
        res[n[RIDX_W-1:0]] = '{cp: CP_W'(data_byte), raw: 1'b0};
        n = n + 3'd1;
      end else if (data_byte[7:5] == TAG_LEAD2) begin
        lead_byte_next = data_byte;
        exp_len_next   = LEN_2;
        held_cnt_next  = 2'd0;
        partial_next   = CP_W'(data_byte[4:0]);
      end else if (data_byte[7:4] == TAG_LEAD3) begin
        lead_byte_next = data_byte;
        exp_len_next   = LEN_3;
        held_cnt_next  = 2'd0;
        partial_next   = CP_W'(data_byte[3:0]);
      end else if (data_byte[7:3] == TAG_LEAD4) begin
        lead_byte_next = data_byte;
        exp_len_next   = LEN_4;
        held_cnt_next  = 2'd0;
        partial_next   = CP_W'(data_byte[2:0]);
      end else begin
        res[n[RIDX_W-1:0]] = '{cp: CP_W'(data_byte), raw: 1'b1};
        n = n + 3'd1;
      end
    end

    // flush an open sequence at end of text
    if (text_end && exp_len_next != LEN_NONE) begin
      res[n[RIDX_W-1:0]] = '{cp: CP_W'(lead_byte_next), raw: 1'b1};
      n = n + 3'd1;
      for (int i = 0; i < HELD_DEPTH; i++) begin
        if (2'(i) < held_cnt_next) begin
          if (hold_wr && 2'(i) == held_cnt) begin
            res[n[RIDX_W-1:0]] = '{cp: CP_W'(data_byte), raw: 1'b1};
          end else begin
            res[n[RIDX_W-1:0]] = '{cp: CP_W'(held[i]), raw: 1'b1};
          end
          n = n + 3'd1;
        end
      end
      exp_len_next   = LEN_NONE;
      held_cnt_next  = 2'd0;
      partial_next   = '0;
      lead_byte_next = 8'd0;
    end
  end

  assign push              = accept && (n != 3'd0);
  assign push_pkt.res      = res;
  assign push_pkt.last_idx = RIDX_W'(n - 3'd1);
  assign push_pkt.text_end = text_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte <= 8'd0;
      exp_len   <= LEN_NONE;
      held_cnt  <= 2'd0;
      partial   <= '0;
    end else if (accept) begin
      lead_byte <= lead_byte_next;
      exp_len   <= exp_len_next;
      held_cnt  <= held_cnt_next;
      partial   <= partial_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_wr) begin
      held[held_cnt[0]] <= data_byte;
    end
  end

endmodule

`default_nettype wire

/* src/utf8d_queue.sv */
// Packet queue between the front end and the output sequencer.
`default_nettype none

module utf8d_queue
  import utf8d_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire pkt_t push_pkt,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output pkt_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pkt_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

endmodule

`default_nettype wire

/* src/utf8d_back.sv */
// Back end: steps through each packet and drives the output register.
`default_nettype none

module utf8d_back
  import utf8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fold_case,
  input  wire logic        head_valid,
  input  wire pkt_t        head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [CP_W-1:0]  code_point,
  output logic             raw_fallback,
  output logic             run_last,
  output logic             final_result
);

  logic [RIDX_W-1:0] idx;
  logic              load;
  logic              last;
  result_t           sel;
  logic [CP_W-1:0]   cp_fold;

  assign load = head_valid && (!out_valid || !out_stall);
  assign sel  = head.res[idx];
  assign last = (idx == head.last_idx);
  assign pop  = load && last;

  always_comb begin
    cp_fold = sel.cp;
    if (fold_case && sel.cp >= CP_UPPER_A && sel.cp <= CP_UPPER_Z) begin
      cp_fold = sel.cp | CP_FOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? '0 : idx + RIDX_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point   <= cp_fold;
      raw_fallback <= sel.raw;
      run_last     <= last;
      final_result <= last && head.text_end;
    end
  end

endmodule

`default_nettype wire

/* src/utf8_lenient_decoder_top.sv */
// Top level of the lenient UTF-8 decoder.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | data_byte, text_end
//  out     | output    | out_valid / out_stall| code_point, raw_fallback, run_last,
//          |           |                      | final_result
//  cfg     | input     | cfg_valid / cfg_ready| fold_case
//
// One byte is taken per cycle while the packet queue has room; a byte that
// yields results lands in the queue the same cycle. The output register sends
// one result per cycle while out_stall is low; a byte with more than one result
// holds the back end and the queue absorbs the burst. A result passes a queue
// slot, then the output register. Reset is synchronous and needs no clearing pass.
`default_nettype none

module utf8_lenient_decoder_top
  import utf8d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      data_byte,
  input  wire logic            text_end,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [CP_W-1:0]      code_point,
  output logic                 raw_fallback,
  output logic                 run_last,
  output logic                 final_result,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            fold_case
);

  logic fold_reg;
  logic push, q_full, pop, head_valid;
  pkt_t push_pkt, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_reg <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      fold_reg <= fold_case;
    end
  end

  utf8d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .text_end  (text_end),
    .q_full    (q_full),
    .push      (push),
    .push_pkt  (push_pkt)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pkt   (push_pkt),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  utf8d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fold_case    (fold_reg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_point   (code_point),
    .raw_fallback (raw_fallback),
    .run_last     (run_last),
    .final_result (final_result)
  );

endmodule

`default_nettype wire
